// ===== src/mi3_pkg.sv =====
// Shared widths, constants and cofactor index tables of the 3x3 matrix inverse unit.
`default_nettype none
package mi3_pkg;
   localparam int N_ELEM        = 9;
   localparam int ELEM_W        = 32;
   localparam int IN_FRAC_BITS  = 16;
   localparam int OUT_FRAC_BITS = 32;
   localparam int PROD_W        = 2 * ELEM_W;
   localparam int ADJ_W         = PROD_W + 1;
   localparam int MAG_W         = ADJ_W;
   localparam int PP_W          = ADJ_W;
   localparam int DET_W         = ADJ_W + ELEM_W + 1;
   localparam int DEN_W         = DET_W - 1;
   localparam int Q_W           = 64;
   localparam int SHIFT         = IN_FRAC_BITS + OUT_FRAC_BITS;
   localparam int NUM_W         = MAG_W + SHIFT;
   localparam int DIV_STEPS     = Q_W;
   localparam int DIV_LAT       = DIV_STEPS + 1;
   localparam int THR_W         = 32;
   localparam logic [THR_W-1:0] THR_RESET = 32'd2814750;

   // Adjugate entry i is m[PA_L]*m[PA_R] - m[PB_L]*m[PB_R], signs folded in.
   localparam int PA_L [N_ELEM] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
   localparam int PA_R [N_ELEM] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
   localparam int PB_L [N_ELEM] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
   localparam int PB_R [N_ELEM] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [ADJ_W-1:0]  adj_type;
   typedef logic signed [PP_W-1:0]   pp_type;
   typedef logic signed [DET_W-1:0]  det_type;
endpackage
`default_nettype wire

// ===== src/mi3_divider.sv =====
// Pipelined restoring divider with Q32.32 scaling, truncation and saturation.
`default_nettype none
module mi3_divider (
   input  wire logic                        clock,
   input  wire logic                        en,
   input  wire logic [mi3_pkg::MAG_W-1:0]   mag,
   input  wire logic [mi3_pkg::DEN_W-1:0]   den,
   input  wire logic                        neg,
   output logic      [mi3_pkg::Q_W-1:0]     q
);
   localparam int DEN_W = mi3_pkg::DEN_W;
   localparam int Q_W   = mi3_pkg::Q_W;
   localparam int NS    = mi3_pkg::DIV_STEPS;

   logic [mi3_pkg::NUM_W-1:0] num;
   logic [DEN_W-1:0] rem_ff [0:NS];
   logic [Q_W-1:0]   lo_ff  [0:NS];
   logic [Q_W-1:0]   q_ff   [0:NS];
   logic [DEN_W-1:0] den_ff [0:NS];
   logic             neg_ff [0:NS];
   logic             big_ff [0:NS];

   assign num = {mag, {mi3_pkg::SHIFT{1'b0}}};

   // The quotient overflows 64 bits exactly when the upper numerator part reaches the divisor.
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= DEN_W'(num[mi3_pkg::NUM_W-1:Q_W]);
         lo_ff[0]  <= num[Q_W-1:0];
         q_ff[0]   <= '0;
         den_ff[0] <= den;
         neg_ff[0] <= neg;
         big_ff[0] <= DEN_W'(num[mi3_pkg::NUM_W-1:Q_W]) >= den;
      end
   end

   for (genvar k = 1; k <= NS; k++) begin : g_step
      logic [DEN_W:0]   trial;
      logic             ge;
      logic [DEN_W:0]   diff;
      assign trial = {rem_ff[k-1], lo_ff[k-1][Q_W-1]};
      assign ge    = trial >= {1'b0, den_ff[k-1]};
      assign diff  = trial - {1'b0, den_ff[k-1]};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            lo_ff[k]  <= {lo_ff[k-1][Q_W-2:0], 1'b0};
            q_ff[k]   <= {q_ff[k-1][Q_W-2:0], ge};
            den_ff[k] <= den_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            big_ff[k] <= big_ff[k-1];
         end
      end
   end

   always_comb begin
      if (neg_ff[NS]) begin
         if (big_ff[NS] || (q_ff[NS] > {1'b1, {(Q_W-1){1'b0}}})) q = {1'b1, {(Q_W-1){1'b0}}};
         else q = Q_W'(0) - q_ff[NS];
      end else begin
         if (big_ff[NS] || q_ff[NS][Q_W-1]) q = {1'b0, {(Q_W-1){1'b1}}};
         else q = q_ff[NS];
      end
   end
endmodule
`default_nettype wire

// ===== src/matrix_inverse_3x3_unit.sv =====
// Throughput: one matrix per cycle; the whole pipeline advances as one, so a stall on
// the result side holds every stage and the input side together.
// The pipeline is made of seven arithmetic stages, the input stage of the dividers, their
// 64 quotient steps and the output register.
// Reset (synchronous, active high) clears all valid bits and sets the threshold to 2814750.
`default_nettype none
module matrix_inverse_3x3_unit (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // m00, m01, m02, m10, m11, m12, m20, m21, m22, 32 bits each
   input  wire logic [287:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // r00, r01, r02, r10, r11, r12, r20, r21, r22, 64 bits each
   output logic [575:0]      rsp_tdata,
   // singular
   output logic [0:0]        rsp_tuser,
   input  wire logic         csr_wr_en,
   input  wire logic [31:0]  csr_wr_data
);
   localparam int NE    = mi3_pkg::N_ELEM;
   localparam int EW    = mi3_pkg::ELEM_W;
   localparam int QW    = mi3_pkg::Q_W;
   localparam int VLEN  = 7 + mi3_pkg::DIV_LAT;

   // The pipeline moves whenever the output register is free or being emptied.
   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   logic [mi3_pkg::THR_W-1:0] thr_ff;
   always_ff @(posedge clock) begin
      if (reset) thr_ff <= mi3_pkg::THR_RESET;
      else if (csr_wr_en) thr_ff <= csr_wr_data;
   end

   // Valid line across all stages, and the singular flag from the decision stage on.
   logic [VLEN-1:0]             vld_ff;
   logic [mi3_pkg::DIV_LAT:0]   sing_ff;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= {vld_ff[VLEN-2:0], req_tvalid};
   end

   // Stage 1: register the matrix entries.
   mi3_pkg::elem_type m_ff [NE];
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NE; i++) m_ff[i] <= req_tdata[i*EW +: EW];
      end
   end

   // Stage 2: the eighteen 32x32 products of the cofactors.
   mi3_pkg::prod_type pa_ff [NE];
   mi3_pkg::prod_type pb_ff [NE];
   mi3_pkg::elem_type r0_s2_ff [3];
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NE; i++) begin
            pa_ff[i] <= mi3_pkg::PROD_W'(m_ff[mi3_pkg::PA_L[i]])
                      * mi3_pkg::PROD_W'(m_ff[mi3_pkg::PA_R[i]]);
            pb_ff[i] <= mi3_pkg::PROD_W'(m_ff[mi3_pkg::PB_L[i]])
                      * mi3_pkg::PROD_W'(m_ff[mi3_pkg::PB_R[i]]);
         end
         for (int i = 0; i < 3; i++) r0_s2_ff[i] <= m_ff[i];
      end
   end

   // Stage 3: adjugate entries, with the cofactor signs folded into the product order.
   mi3_pkg::adj_type adj3_ff [NE];
   mi3_pkg::elem_type r0_s3_ff [3];
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NE; i++)
            adj3_ff[i] <= mi3_pkg::ADJ_W'(pa_ff[i]) - mi3_pkg::ADJ_W'(pb_ff[i]);
         r0_s3_ff <= r0_s2_ff;
      end
   end

   // Stage 4: each 65-bit cofactor times its row-0 entry, split into two 33x32 products.
   mi3_pkg::pp_type  pl_ff [3];
   mi3_pkg::pp_type  ph_ff [3];
   mi3_pkg::adj_type adj4_ff [NE];
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            pl_ff[i] <= mi3_pkg::PP_W'($signed({1'b0, adj3_ff[3*i][31:0]}))
                      * mi3_pkg::PP_W'(r0_s3_ff[i]);
            ph_ff[i] <= mi3_pkg::PP_W'($signed(adj3_ff[3*i][mi3_pkg::ADJ_W-1:32]))
                      * mi3_pkg::PP_W'(r0_s3_ff[i]);
         end
         adj4_ff <= adj3_ff;
      end
   end

   // Stage 5: recombine the halves of each determinant term.
   mi3_pkg::det_type term_ff [3];
   mi3_pkg::adj_type adj5_ff [NE];
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++)
            term_ff[i] <= (mi3_pkg::DET_W'(ph_ff[i]) <<< 32) + mi3_pkg::DET_W'(pl_ff[i]);
         adj5_ff <= adj4_ff;
      end
   end

   // Stage 6: the determinant by expansion along row 0.
   mi3_pkg::det_type det_ff;
   mi3_pkg::adj_type adj6_ff [NE];
   always_ff @(posedge clock) begin
      if (en) begin
         det_ff  <= term_ff[0] + term_ff[1] + term_ff[2];
         adj6_ff <= adj5_ff;
      end
   end

   // Stage 7: magnitudes, signs and the singular decision.
   logic                         det_neg;
   mi3_pkg::det_type             det_abs;
   logic [mi3_pkg::DEN_W-1:0]    den_ff;
   logic [mi3_pkg::MAG_W-1:0]    mag_ff [NE];
   logic                         neg_ff [NE];
   assign det_neg = det_ff[mi3_pkg::DET_W-1];
   assign det_abs = det_neg ? -det_ff : det_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff     <= det_abs[mi3_pkg::DEN_W-1:0];
         // A zero determinant counts as singular even with a zero threshold.
         sing_ff[0] <= (det_ff == '0)
                    || (det_abs[mi3_pkg::DEN_W-1:0] < mi3_pkg::DEN_W'(thr_ff));
         for (int i = 0; i < NE; i++) begin
            mag_ff[i] <= adj6_ff[i][mi3_pkg::ADJ_W-1] ? mi3_pkg::MAG_W'(-adj6_ff[i])
                                                       : mi3_pkg::MAG_W'(adj6_ff[i]);
            neg_ff[i] <= adj6_ff[i][mi3_pkg::ADJ_W-1] ^ det_neg;
         end
         sing_ff[mi3_pkg::DIV_LAT:1] <= sing_ff[mi3_pkg::DIV_LAT-1:0];
      end
   end

   // Nine dividers in lockstep, one per adjugate entry.
   logic [QW-1:0] quo [NE];
   for (genvar i = 0; i < NE; i++) begin : g_div
      mi3_divider u_div (
         .clock (clock),
         .en    (en),
         .mag   (mag_ff[i]),
         .den   (den_ff),
         .neg   (neg_ff[i]),
         .q     (quo[i])
      );
   end

   // Output register: a singular matrix gives an all-zero beat.
   logic [575:0] rsp_tdata_ff;
   logic [575:0] rsp_tdata_in;
   logic         rsp_tvalid_ff;
   logic         rsp_sing_ff;

   always_comb begin
      for (int i = 0; i < NE; i++)
         rsp_tdata_in[i*QW +: QW] = sing_ff[mi3_pkg::DIV_LAT] ? '0 : quo[i];
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_tvalid_ff <= 1'b0;
      else if (en) rsp_tvalid_ff <= vld_ff[VLEN-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_sing_ff  <= sing_ff[mi3_pkg::DIV_LAT];
      end
   end

   assign rsp_tvalid   = rsp_tvalid_ff;
   assign rsp_tdata    = rsp_tdata_ff;
   assign rsp_tuser[0] = rsp_sing_ff;

`ifndef NO_ASSERTIONS
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("singular beat carries nonzero data");

   a_hold_line: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("valid line moved during a stall");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_tvalid && (vld_ff == '0)))
      else $error("pipeline not empty after reset");
`endif
endmodule
`default_nettype wire
